// ===== sv/pghist_pkg.sv =====
package pghist_pkg;

  // dimension and counter widths, bin count and bin address width
  localparam int DIM_BITS   = 16;
  localparam int COUNT_BITS = 32;
  localparam int BIN_NUM    = 256;
  localparam int BIN_AW     = $clog2(BIN_NUM);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // header bytes
  localparam logic [7:0] MAGIC_P   = 8'h50;
  localparam logic [7:0] MAGIC_5   = 8'h35;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_SEP    = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_MAXVAL = 3'd4,
    PH_PIXELS = 3'd5,
    PH_END    = 3'd6
  } phase_e;

  // bin store update from the parser
  typedef struct packed {
    logic                  wr_en;
    logic [BIN_AW-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
    logic                  clear;
  } bin_cmd_t;

  // one result transaction
  typedef struct packed {
    phase_e                phase;
    logic                  header_error;
    logic [DIM_BITS-1:0]   image_width;
    logic [DIM_BITS-1:0]   image_height;
    logic [COUNT_BITS-1:0] pixels_seen;
    logic                  image_done;
    logic [COUNT_BITS-1:0] bin_count;
  } res_t;

endpackage

// ===== sv/pghist_bins.sv =====
module pghist_bins (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       rd_en_i,
  input  logic [pghist_pkg::BIN_AW-1:0]              rd_addr_i,
  input  pghist_pkg::bin_cmd_t                       cmd_i,
  output logic [pghist_pkg::COUNT_BITS-1:0]          count_o
);

  logic [pghist_pkg::COUNT_BITS-1:0] mem_q [pghist_pkg::BIN_NUM];
  logic [pghist_pkg::COUNT_BITS-1:0] rd_q;
  logic [pghist_pkg::BIN_AW-1:0]     addr_q;
  logic [pghist_pkg::BIN_NUM-1:0]    vld_q;
  logic                              lw_vld_q;
  logic [pghist_pkg::BIN_AW-1:0]     lw_addr_q;
  logic [pghist_pkg::COUNT_BITS-1:0] lw_data_q;

  // bin memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q   <= mem_q[rd_addr_i];
      addr_q <= rd_addr_i;
    end
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.addr] <= cmd_i.data;
    end
  end

  // per-bin valid flags and last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      lw_vld_q <= 1'b0;
    end else if (cmd_i.clear) begin
      vld_q    <= '0;
      lw_vld_q <= 1'b0;
    end else if (cmd_i.wr_en) begin
      vld_q[cmd_i.addr] <= 1'b1;
      lw_vld_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      lw_addr_q <= cmd_i.addr;
      lw_data_q <= cmd_i.data;
    end
  end

  // the latest write may have landed on the edge the read was taken
  always_comb begin
    if (lw_vld_q && (lw_addr_q == addr_q)) begin
      count_o = lw_data_q;
    end else if (vld_q[addr_q]) begin
      count_o = rd_q;
    end else begin
      count_o = '0;
    end
  end

endmodule

// ===== sv/pghist_parser.sv =====
module pghist_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic                              op_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              start_of_file_i,
  input  logic [pghist_pkg::COUNT_BITS-1:0] count_i,
  output pghist_pkg::bin_cmd_t              cmd_o,
  output pghist_pkg::res_t                  res_o
);

  localparam int DW    = pghist_pkg::DIM_BITS;
  localparam int CW    = pghist_pkg::COUNT_BITS;
  localparam int XW    = DW + 4;
  localparam int PW    = 2 * DW;
  localparam int TGT_W = (PW > CW) ? PW : CW;
  localparam logic [XW-1:0] DIM_MAX_X = XW'((64'd1 << DW) - 64'd1);

  pghist_pkg::phase_e ph_q, ph_d, b_ph;
  logic          mp_q, mp_d, b_mp;
  logic [DW-1:0] w_q, w_d, b_w;
  logic [DW-1:0] h_q, h_d, b_h;
  logic [CW-1:0] cnt_q, cnt_d, b_cnt;
  logic          err_q, err_d, b_err;
  logic [CW-1:0] tgt_q;

  logic [PW-1:0]    prod;
  logic [TGT_W-1:0] prod_x;
  logic [DW-1:0]    dim_sel;
  logic [XW-1:0]    dim_x10;
  logic             is_digit;
  logic             dim_ovf;
  logic [CW:0]      cnt_inc;
  logic [CW-1:0]    bin_inc;

  // pixel target, computed while the maxval line is skipped
  assign prod   = PW'(w_q) * PW'(h_q);
  assign prod_x = TGT_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (ph_q == pghist_pkg::PH_MAXVAL) begin
      tgt_q <= (prod_x > TGT_W'(pghist_pkg::COUNT_MAX)) ? pghist_pkg::COUNT_MAX
                                                         : prod_x[CW-1:0];
    end
  end

  // decimal digit accumulation for the dimension being parsed
  assign dim_sel  = (ph_q == pghist_pkg::PH_WIDTH) ? w_q : h_q;
  assign is_digit = (data_byte_i >= pghist_pkg::CHAR_ZERO) &&
                    (data_byte_i <= pghist_pkg::CHAR_NINE);
  assign dim_x10  = (XW'(dim_sel) << 3) + (XW'(dim_sel) << 1) +
                    XW'(data_byte_i[3:0] - pghist_pkg::CHAR_ZERO[3:0]);
  assign dim_ovf  = dim_x10 > DIM_MAX_X;

  assign cnt_inc = {1'b0, cnt_q} + {{CW{1'b0}}, 1'b1};
  assign bin_inc = (count_i == pghist_pkg::COUNT_MAX) ? count_i : count_i + CW'(1);

  // next state for one transaction
  always_comb begin
    b_ph  = ph_q;
    b_mp  = mp_q;
    b_w   = w_q;
    b_h   = h_q;
    b_cnt = cnt_q;
    b_err = err_q;
    cmd_o = '0;
    if (start_of_file_i) begin
      b_ph  = pghist_pkg::PH_MAGIC;
      b_mp  = 1'b0;
      b_w   = '0;
      b_h   = '0;
      b_cnt = '0;
      b_err = 1'b0;
    end
    ph_d  = ph_q;
    mp_d  = mp_q;
    w_d   = w_q;
    h_d   = h_q;
    cnt_d = cnt_q;
    err_d = err_q;
    if (op_i == pghist_pkg::OP_BYTE) begin
      ph_d  = b_ph;
      mp_d  = b_mp;
      w_d   = b_w;
      h_d   = b_h;
      cnt_d = b_cnt;
      err_d = b_err;
      cmd_o.clear = fire_i && start_of_file_i;
      case (b_ph)
        pghist_pkg::PH_MAGIC: begin
          if (!b_mp) begin
            if (data_byte_i != pghist_pkg::MAGIC_P) begin
              err_d = 1'b1;
              ph_d  = pghist_pkg::PH_END;
            end else begin
              mp_d = 1'b1;
            end
          end else if (data_byte_i != pghist_pkg::MAGIC_5) begin
            err_d = 1'b1;
            ph_d  = pghist_pkg::PH_END;
          end else begin
            ph_d = pghist_pkg::PH_SEP;
          end
        end
        pghist_pkg::PH_SEP: begin
          ph_d = pghist_pkg::PH_WIDTH;
        end
        pghist_pkg::PH_WIDTH: begin
          if (data_byte_i == pghist_pkg::CHAR_SP) begin
            ph_d = pghist_pkg::PH_HEIGHT;
          end else if (!is_digit || dim_ovf) begin
            err_d = 1'b1;
            ph_d  = pghist_pkg::PH_END;
          end else begin
            w_d = dim_x10[DW-1:0];
          end
        end
        pghist_pkg::PH_HEIGHT: begin
          if (data_byte_i == pghist_pkg::CHAR_LF) begin
            ph_d = pghist_pkg::PH_MAXVAL;
          end else if (!is_digit || dim_ovf) begin
            err_d = 1'b1;
            ph_d  = pghist_pkg::PH_END;
          end else begin
            h_d = dim_x10[DW-1:0];
          end
        end
        pghist_pkg::PH_MAXVAL: begin
          if (data_byte_i == pghist_pkg::CHAR_LF) begin
            ph_d = ((w_q == '0) || (h_q == '0)) ? pghist_pkg::PH_END
                                                : pghist_pkg::PH_PIXELS;
          end
        end
        pghist_pkg::PH_PIXELS: begin
          cmd_o.wr_en = fire_i;
          cmd_o.addr  = data_byte_i;
          cmd_o.data  = bin_inc;
          cnt_d       = cnt_inc[CW-1:0];
          if (cnt_inc >= {1'b0, tgt_q}) begin
            ph_d = pghist_pkg::PH_END;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= pghist_pkg::PH_MAGIC;
      mp_q  <= 1'b0;
      w_q   <= '0;
      h_q   <= '0;
      cnt_q <= '0;
      err_q <= 1'b0;
    end else if (fire_i) begin
      ph_q  <= ph_d;
      mp_q  <= mp_d;
      w_q   <= w_d;
      h_q   <= h_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // state after the transaction
  always_comb begin
    res_o.phase        = ph_d;
    res_o.header_error = err_d;
    res_o.image_width  = w_d;
    res_o.image_height = h_d;
    res_o.pixels_seen  = cnt_d;
    res_o.image_done   = (ph_d == pghist_pkg::PH_END) && !err_d;
    res_o.bin_count    = (op_i == pghist_pkg::OP_READ) ? count_i : '0;
  end

endmodule

// ===== sv/pgm_header_parse_histogram_top.sv =====
// an accepted transaction is held in the input register, then its result in the output register
// throughput: one transaction per cycle while the output is not stalled, file bytes and bin reads alike
// the bin memory read-modify-write is split over the input and stage registers,
// with the latest write forwarded, which sets the one-per-cycle figure
// reset (rst_ni low, asynchronous): parser at magic, all bins read as zero,
// no clearing pass; a start-of-file byte clears the bins in the same cycle
module pgm_header_parse_histogram_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [7:0]                        data_byte_i,
  input  logic                              start_of_file_i,
  input  logic [7:0]                        bin_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        phase_o,
  output logic                              header_error_o,
  output logic [pghist_pkg::DIM_BITS-1:0]   image_width_o,
  output logic [pghist_pkg::DIM_BITS-1:0]   image_height_o,
  output logic [pghist_pkg::COUNT_BITS-1:0] pixels_seen_o,
  output logic                              image_done_o,
  output logic [pghist_pkg::COUNT_BITS-1:0] bin_count_o
);

  logic                              s1_vld_q;
  logic                              s1_op_q;
  logic [7:0]                        s1_byte_q;
  logic                              s1_sof_q;
  logic                              out_vld_q;
  pghist_pkg::res_t                  out_q;
  logic                              accept;
  logic                              fire;
  logic [pghist_pkg::BIN_AW-1:0]     rd_addr;
  logic [pghist_pkg::COUNT_BITS-1:0] count;
  pghist_pkg::bin_cmd_t              cmd;
  pghist_pkg::res_t                  res;

  // handshake
  assign fire       = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_addr    = (op_i == pghist_pkg::OP_READ) ? bin_index_i : data_byte_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= op_i;
      s1_byte_q <= rd_addr;
      s1_sof_q  <= start_of_file_i;
    end
  end

  pghist_bins u_bins (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .cmd_i     (cmd),
    .count_o   (count)
  );

  pghist_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .op_i            (s1_op_q),
    .data_byte_i     (s1_byte_q),
    .start_of_file_i (s1_sof_q),
    .count_i         (count),
    .cmd_o           (cmd),
    .res_o           (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign phase_o        = out_q.phase;
  assign header_error_o = out_q.header_error;
  assign image_width_o  = out_q.image_width;
  assign image_height_o = out_q.image_height;
  assign pixels_seen_o  = out_q.pixels_seen;
  assign image_done_o   = out_q.image_done;
  assign bin_count_o    = out_q.bin_count;

`ifndef NO_ASSERTIONS
  // a held result and a full input register must stall the input side
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted with no room downstream");

  // a transaction leaving the input register shows up as a result
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("transaction lost between stages");

  // an error always ends the file
  a_error_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && header_error_o) |-> (phase_o == pghist_pkg::PH_END))
    else $error("error flagged outside the end phase");

  // the pixel phase is only entered with a non-empty image
  a_pixels_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (phase_o == pghist_pkg::PH_PIXELS)) |->
      ((image_width_o != '0) && (image_height_o != '0)))
    else $error("pixel phase with an empty image");
`endif

endmodule

// ===== verif/pgm_header_parse_histogram_top_tb.sv =====
module pgm_header_parse_histogram_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pghist_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint unsigned DIM_LIMIT = (64'd1 << DIM_BITS) - 64'd1;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic                  op_i            = OP_BYTE;
  logic [7:0]            data_byte_i     = 8'h00;
  logic                  start_of_file_i = 1'b0;
  logic [7:0]            bin_index_i     = 8'h00;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [2:0]            phase_o;
  logic                  header_error_o;
  logic [DIM_BITS-1:0]   image_width_o;
  logic [DIM_BITS-1:0]   image_height_o;
  logic [COUNT_BITS-1:0] pixels_seen_o;
  logic                  image_done_o;
  logic [COUNT_BITS-1:0] bin_count_o;

  // parser and histogram state as the block should hold it
  phase_e                hist_phase;
  logic                  magic_second;
  logic [DIM_BITS-1:0]   hist_width;
  logic [DIM_BITS-1:0]   hist_height;
  logic [COUNT_BITS-1:0] hist_pixels;
  logic                  hist_error;
  logic [COUNT_BITS-1:0] hist_bins [BIN_NUM];

  res_t        parser_reports_due[$];
  int unsigned items_taken    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          quiet          = 1'b0;

  pgm_header_parse_histogram_top dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pgm_header_parse_histogram_top regression: fail");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  function automatic void clear_histogram_file();
    hist_phase   = PH_MAGIC;
    magic_second = 1'b0;
    hist_width   = '0;
    hist_height  = '0;
    hist_pixels  = '0;
    hist_error   = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
  endfunction

  function automatic void header_fail();
    hist_error = 1'b1;
    hist_phase = PH_END;
  endfunction

  // one dimension character; returns 1 on the terminator
  function automatic logic dim_char(inout logic [DIM_BITS-1:0] dim, input logic [7:0] b,
                                    input logic [7:0] term);
    longint unsigned grown;
    if (b == term) return 1'b1;
    if (b < CHAR_ZERO || b > CHAR_NINE) begin
      header_fail();
      return 1'b0;
    end
    grown = 64'(dim) * 64'd10 + 64'(b - CHAR_ZERO);
    // overflow keeps the value held before the digit
    if (grown > DIM_LIMIT) header_fail();
    else dim = grown[DIM_BITS-1:0];
    return 1'b0;
  endfunction

  function automatic longint unsigned pixel_goal();
    longint unsigned goal;
    goal = 64'(hist_width) * 64'(hist_height);
    return (goal > 64'(COUNT_MAX)) ? 64'(COUNT_MAX) : goal;
  endfunction

  function automatic void parse_file_byte(logic [7:0] b);
    case (hist_phase)
      PH_MAGIC: begin
        if (!magic_second) begin
          if (b != MAGIC_P) header_fail();
          else magic_second = 1'b1;
        end else if (b != MAGIC_5) begin
          header_fail();
        end else begin
          hist_phase = PH_SEP;
        end
      end
      PH_SEP: hist_phase = PH_WIDTH;
      PH_WIDTH: begin
        if (dim_char(hist_width, b, CHAR_SP)) hist_phase = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        if (dim_char(hist_height, b, CHAR_LF)) hist_phase = PH_MAXVAL;
      end
      PH_MAXVAL: begin
        if (b == CHAR_LF) hist_phase = (pixel_goal() == 0) ? PH_END : PH_PIXELS;
      end
      PH_PIXELS: begin
        // bins saturate
        if (hist_bins[b] != COUNT_MAX) hist_bins[b] = hist_bins[b] + 1'b1;
        hist_pixels = hist_pixels + 1'b1;
        if (64'(hist_pixels) >= pixel_goal()) hist_phase = PH_END;
      end
      default: ;
    endcase
  endfunction

  // state update and report for one accepted transaction
  function automatic res_t histogram_step(logic op, logic [7:0] b, logic sof,
                                          logic [7:0] idx);
    res_t rep;
    // every accepted transaction counts as stimulus
    items_taken++;
    if (op == OP_BYTE) begin
      if (sof) clear_histogram_file();
      parse_file_byte(b);
    end
    rep.phase        = hist_phase;
    rep.header_error = hist_error;
    rep.image_width  = hist_width;
    rep.image_height = hist_height;
    rep.pixels_seen  = hist_pixels;
    rep.image_done   = (hist_phase == PH_END) && !hist_error;
    rep.bin_count    = (op == OP_READ) ? hist_bins[idx] : '0;
    return rep;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // compare each report with the oldest one due
  always @(posedge clk_i) begin : check_reports
    res_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parser_reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: report with none due, phase %0d", $time, phase_o);
      end else begin
        due = parser_reports_due.pop_front();
        check_field("phase", due.phase, phase_o);
        check_field("header_error", due.header_error, header_error_o);
        check_field("image_width", due.image_width, image_width_o);
        check_field("image_height", due.image_height, image_height_o);
        check_field("pixels_seen", due.pixels_seen, pixels_seen_o);
        check_field("image_done", due.image_done, image_done_o);
        check_field("bin_count", due.bin_count, bin_count_o);
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic op, logic [7:0] b, logic sof, logic [7:0] idx);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    data_byte_i     <= b;
    start_of_file_i <= sof;
    bin_index_i     <= idx;
    do @(posedge clk_i); while (in_stall_o);
    parser_reports_due.push_back(histogram_step(op, b, sof, idx));
  endtask

  task automatic send_text(string txt, logic sof);
    for (int i = 0; i < txt.len(); i++)
      send_item(OP_BYTE, txt[i], sof && (i == 0), 8'h00);
  endtask

  function automatic logic [7:0] hot_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h0A;
    endcase
  endfunction

  task automatic random_read();
    logic [7:0] idx;
    idx = $urandom_range(0, 1) ? hot_byte() : 8'($urandom);
    send_item(OP_READ, 8'($urandom), 1'($urandom), idx);
  endtask

  // decimal text for a dimension: mostly small, else empty, zero, large or too big
  function automatic string random_dim(int unsigned small_max);
    int unsigned pick;
    string txt;
    pick = $urandom_range(0, 99);
    if (pick < 6) txt = "";
    else if (pick < 12) txt = "0";
    else if (pick < 18) txt = $sformatf("%0d", $urandom_range(1000, 65534));
    else if (pick < 23) txt = "65535";
    else if (pick < 29) txt = $sformatf("%0d", $urandom_range(65536, 99999));
    else txt = $sformatf("%0d", $urandom_range(1, small_max));
    if ($urandom_range(0, 9) == 0) txt = {"0", txt};
    return txt;
  endfunction

  // one file, mostly well formed, with reads mixed in
  task automatic random_file();
    logic [7:0] file_bytes[$];
    logic [7:0] b;
    string w_txt, h_txt;
    longint unsigned goal;
    int unsigned pix_num, head_len, cut;
    w_txt = random_dim(6);
    h_txt = random_dim(4);
    file_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : MAGIC_P);
    file_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : MAGIC_5);
    file_bytes.push_back(8'($urandom));
    for (int i = 0; i < w_txt.len(); i++) file_bytes.push_back(w_txt[i]);
    file_bytes.push_back(CHAR_SP);
    for (int i = 0; i < h_txt.len(); i++) file_bytes.push_back(h_txt[i]);
    file_bytes.push_back(CHAR_LF);
    // maxval line
    if ($urandom_range(0, 2) != 0) begin
      file_bytes.push_back("2");
      file_bytes.push_back("5");
      file_bytes.push_back("5");
    end else begin
      repeat ($urandom_range(0, 3)) begin
        b = 8'($urandom);
        file_bytes.push_back((b == CHAR_LF) ? CHAR_NINE : b);
      end
    end
    file_bytes.push_back(CHAR_LF);
    head_len = file_bytes.size();
    // big images are cut short and restarted by the next file
    goal = 64'(w_txt.atoi()) * 64'(h_txt.atoi());
    pix_num = (goal <= 60) ? int'(goal) : $urandom_range(0, 60);
    repeat (pix_num) file_bytes.push_back($urandom_range(0, 1) ? hot_byte() : 8'($urandom));
    repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom));
    // broken sequences: a garbled header byte or a truncated file
    if ($urandom_range(0, 9) == 0)
      file_bytes[$urandom_range(0, head_len - 1)] = 8'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(0, file_bytes.size() - 1);
      repeat (cut) void'(file_bytes.pop_back());
    end
    for (int i = 0; i < file_bytes.size(); i++) begin
      if ($urandom_range(0, 9) == 0) random_read();
      send_item(OP_BYTE, file_bytes[i], i == 0, 8'($urandom));
    end
    repeat ($urandom_range(1, 3)) random_read();
  endtask

  // reads straight after reset see empty bins, the start mark is ignored on a read
  task automatic test_reads_after_reset();
    send_item(OP_READ, 8'hFF, 1'b1, 8'h00);
    send_item(OP_READ, 8'h00, 1'b0, 8'hFF);
  endtask

  // wrong first magic byte, then wrong second one
  task automatic test_bad_magic();
    send_text("Q", 1'b1);
    send_text("P4", 1'b1);
  endtask

  // one by two image with extreme pixels, a byte past the end, then a read
  task automatic test_small_image();
    send_text("P5\n1 2\n\n", 1'b1);
    send_item(OP_BYTE, 8'h00, 1'b0, 8'h00);
    send_item(OP_BYTE, 8'hFF, 1'b0, 8'h00);
    send_item(OP_BYTE, MAGIC_P, 1'b0, 8'h00);
    send_item(OP_READ, 8'h00, 1'b1, 8'hFF);
  endtask

  // empty width gives a zero-pixel image that ends at the maxval newline
  task automatic test_empty_image();
    send_text("P5  1\n\n", 1'b1);
  endtask

  task automatic test_dim_overflow();
    send_text("P5 65536", 1'b1);
  endtask

  // character just below the digit range
  task automatic test_non_digit();
    send_text("P5 /", 1'b1);
  endtask

  task automatic test_random_files();
    int unsigned base;
    base = items_taken;
    while (items_taken - base < RANDOM_ITEMS) begin
      // a stretch with no idling on either side
      quiet = (items_taken - base >= 200) && (items_taken - base < 300);
      random_file();
    end
    quiet = 1'b0;
  endtask

  initial begin
    clear_histogram_file();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reads_after_reset();
    test_bad_magic();
    test_small_image();
    test_empty_image();
    test_dim_overflow();
    test_non_digit();
    test_random_files();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    // drain, then allow for stray reports
    while (parser_reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("pgm_header_parse_histogram_top regression: pass");
    end else begin
      $display("pgm_header_parse_histogram_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== pgm_header_parse_histogram_top.f =====
sv/pghist_pkg.sv
sv/pghist_bins.sv
sv/pghist_parser.sv
sv/pgm_header_parse_histogram_top.sv
verif/pgm_header_parse_histogram_top_tb.sv
